### rtl/hsr_pkg.sv
package hsr_pkg;

    localparam int OP_W      = 3;
    localparam int ROW_W     = 10;
    localparam int WVAL_W    = 16;
    localparam int ITER_W    = 32;
    localparam int ENERGY_W  = 37;
    localparam int ACT_W     = 11;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam int ROW_LSB   = 0;
    localparam int COL_LSB   = 10;
    localparam int WVAL_LSB  = 20;
    localparam int NIN_BIT   = 36;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 11'd1024;
    localparam logic             REG_ACTIVE   = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_WR_WEIGHT = 3'd0,
        OP_WR_NEURON = 3'd1,
        OP_RD_NEURON = 3'd2,
        OP_UPDATE    = 3'd3,
        OP_ENERGY    = 3'd4,
        OP_CLR_COUNT = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WMUL,
        ST_WADDR,
        ST_RDWAIT,
        ST_ROW,
        ST_SCAN,
        ST_DRAIN,
        ST_ROWEND,
        ST_COPY,
        ST_CDRAIN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic field_clr;
        logic field_en;
        logic s_bit;
        logic energy_clr;
        logic energy_en;
        logic si_bit;
    } acc_ctrl_t;

    typedef struct packed {
        logic sweep_init;
        logic row_adv;
        logic row_init;
        logic col_adv;
        logic mul_load;
        logic sel_write;
    } slot_ctrl_t;

endpackage

### rtl/hsr_ram.sv
module hsr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/hsr_slot.sv
module hsr_slot import hsr_pkg::*; #(
    parameter int MAX_NEURONS = 1024,
    parameter int IDX_W       = 10,
    parameter int ADDR_W      = 19
) (
    input  logic              aclk,
    input  slot_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]  sweep_i,
    input  logic [IDX_W-1:0]  sweep_j,
    input  logic [IDX_W-1:0]  pair_a,
    input  logic [IDX_W-1:0]  pair_b,
    output logic [ADDR_W-1:0] slot_addr
);

    localparam int PAIR_COUNT = MAX_NEURONS * (MAX_NEURONS - 1) / 2;
    localparam int BASE_W     = $clog2(PAIR_COUNT + 1);
    localparam int PROD_W     = 2 * IDX_W + 1;

    logic [BASE_W-1:0] rowbase_reg;
    logic [BASE_W-1:0] colbase_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [IDX_W-1:0]  off_lower;
    logic [IDX_W-1:0]  off_upper;
    logic [IDX_W-1:0]  off_pair;
    logic [BASE_W-1:0] sweep_sum;
    logic [PROD_W-2:0] write_sum;

    assign lo        = (pair_a < pair_b) ? pair_a : pair_b;
    assign hi        = (pair_a < pair_b) ? pair_b : pair_a;
    assign off_lower = sweep_i - sweep_j - IDX_W'(1);
    assign off_upper = sweep_j - sweep_i - IDX_W'(1);
    assign off_pair  = hi - lo - IDX_W'(1);

    always_comb begin
        if (sweep_j < sweep_i) begin
            sweep_sum = colbase_reg + BASE_W'(off_lower);
        end else begin
            sweep_sum = rowbase_reg + BASE_W'(off_upper);
        end
        write_sum = prod_reg[PROD_W-1:1] + (PROD_W-1)'(off_pair);
        if (ctrl.sel_write) begin
            slot_addr = ADDR_W'(write_sum);
        end else begin
            slot_addr = ADDR_W'(sweep_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.sweep_init) begin
            rowbase_reg <= '0;
        end else if (ctrl.row_adv) begin
            rowbase_reg <= rowbase_reg + BASE_W'(MAX_NEURONS - 1) - BASE_W'(sweep_i);
        end
        if (ctrl.row_init) begin
            colbase_reg <= '0;
        end else if (ctrl.col_adv) begin
            colbase_reg <= colbase_reg + BASE_W'(MAX_NEURONS - 1) - BASE_W'(sweep_j);
        end
        if (ctrl.mul_load) begin
            prod_reg <= PROD_W'(lo) * (PROD_W'(2 * MAX_NEURONS - 1) - PROD_W'(lo));
        end
    end

endmodule

### rtl/hsr_accum.sv
module hsr_accum import hsr_pkg::*; #(
    parameter int WEIGHT_BITS = 16,
    parameter int FIELD_W     = 27,
    parameter int EACC_W      = 38
) (
    input  logic                          aclk,
    input  acc_ctrl_t                     ctrl,
    input  logic signed [WEIGHT_BITS-1:0] weight,
    output logic                          field_neg,
    output logic        [ENERGY_W-1:0]    energy_sat
);

    localparam int SAT_W = (EACC_W + 1 > ENERGY_W + 1) ? EACC_W + 1 : ENERGY_W + 1;
    localparam logic signed [SAT_W-1:0] EMAX = SAT_W'(64'sd68719476735);
    localparam logic signed [SAT_W-1:0] EMIN = SAT_W'(-64'sd68719476736);

    logic signed [FIELD_W-1:0] field_reg;
    logic signed [EACC_W-1:0]  energy_reg;
    logic signed [FIELD_W-1:0] w_ext;
    logic signed [EACC_W-1:0]  h_ext;
    logic signed [SAT_W-1:0]   neg;

    assign w_ext     = FIELD_W'(weight);
    assign h_ext     = EACC_W'(field_reg);
    assign field_neg = field_reg[FIELD_W-1];

    always_ff @(posedge aclk) begin
        if (ctrl.field_clr) begin
            field_reg <= '0;
        end else if (ctrl.field_en) begin
            field_reg <= ctrl.s_bit ? field_reg + w_ext : field_reg - w_ext;
        end
        if (ctrl.energy_clr) begin
            energy_reg <= '0;
        end else if (ctrl.energy_en) begin
            energy_reg <= ctrl.si_bit ? energy_reg + h_ext : energy_reg - h_ext;
        end
    end

    always_comb begin
        neg = -SAT_W'(energy_reg);
        if (neg > EMAX) begin
            energy_sat = ENERGY_W'(EMAX);
        end else if (neg < EMIN) begin
            energy_sat = ENERGY_W'(EMIN);
        end else begin
            energy_sat = ENERGY_W'(neg);
        end
    end

endmodule

### rtl/hopfield_synchronous_recall.sv
// Hopfield associative memory with synchronous recall.
// Requests enter on s_tvalid/s_tready: s_tuser carries the operation, s_tdata the
// indexes, the weight and the neuron value. Every request gives exactly one result on
// m_tvalid/m_tready. active_neurons is to be written over the APB port only while the
// block is idle; the block itself does not enforce this. Valid weight writes pass ST_WMUL
// and ST_WADDR, valid neuron reads pass ST_RDWAIT before ST_FIN, and other single-table
// operations go straight to ST_FIN. Update and energy sweep the rows of the clamped
// active count with one weight read and one signed accumulate per cycle through the
// single weight memory port; update adds a copy pass that moves next states into the neuron memory.
// One request is worked at a time; s_tready is high only while idle.
// A finished result sits in the output register; the block goes idle and takes the
// next request while m_tready is low, but holds that request's result until the
// output register is taken.
// Reset clears the iteration counter and sets active_neurons to 1024. Weight and
// neuron memories are not cleared: entries read before being written are undefined.
module hopfield_synchronous_recall import hsr_pkg::*; #(
    parameter int MAX_NEURONS = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // row[9:0], column[19:10], weight_value[35:20], neuron_in[36], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation[2:0]
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // neuron_out[0], state_changed[1], iteration[33:2], energy_twice[70:34], bad_index[71]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int IDX_W      = $clog2(MAX_NEURONS);
    localparam int CNT_W      = $clog2(MAX_NEURONS + 1);
    localparam int PAIR_COUNT = MAX_NEURONS * (MAX_NEURONS - 1) / 2;
    localparam int ADDR_W     = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
    localparam int FIELD_W    = WEIGHT_BITS + IDX_W + 1;
    localparam int EACC_W     = FIELD_W + IDX_W + 1;
    localparam int CMP_W      = (CNT_W > ACT_W) ? CNT_W : ACT_W;
    localparam int WX_W       = (WEIGHT_BITS > WVAL_W) ? WEIGHT_BITS : WVAL_W;
    localparam logic signed [WX_W-1:0] WMAX = WX_W'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
    localparam logic signed [WX_W-1:0] WMIN = -WMAX - WX_W'(1);

    state_t state_reg, state_next;

    op_t                     op_reg;
    logic [IDX_W-1:0]        row_reg;
    logic [IDX_W-1:0]        col_reg;
    logic [WEIGHT_BITS-1:0]  wval_reg;
    logic                    bad_reg;
    logic                    nout_reg;
    logic                    changed_reg;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic [ACT_W-1:0]        active_reg;
    logic [IDX_W-1:0]        last_reg;
    logic [IDX_W-1:0]        i_reg;
    logic [IDX_W-1:0]        j_reg;
    logic                    accuse_reg;
    logic                    cpv_reg;
    logic [IDX_W-1:0]        cpidx_reg;
    logic                    si_pend_reg;
    logic                    si_reg;
    logic                    m_valid_reg;
    logic [M_TDATA_W-1:0]    m_data_reg;

    logic                    s_accept;
    op_t                     in_op;
    logic [ROW_W-1:0]        in_row;
    logic [ROW_W-1:0]        in_col;
    logic signed [WVAL_W-1:0] in_wval;
    logic                    in_nin;
    logic                    row_ok;
    logic                    col_ok;
    logic                    pair_bad;
    logic                    in_bad;
    logic signed [WX_W-1:0]  wv_ext;
    logic [WEIGHT_BITS-1:0]  wv_sat;
    logic [CMP_W-1:0]        act_ext;
    logic [CMP_W-1:0]        act_count;
    logic                    out_free;
    logic                    fin_load;
    logic                    cfg_write;

    logic                    nram_we;
    logic [IDX_W-1:0]        nram_waddr;
    logic                    nram_wdata;
    logic [IDX_W-1:0]        nram_raddr;
    logic                    nram_rdata;
    logic                    xram_we;
    logic                    xram_rdata;
    logic                    wram_we;
    logic [WEIGHT_BITS-1:0]  wram_rdata;
    logic [ADDR_W-1:0]       slot_addr;
    acc_ctrl_t               acc_ctrl;
    slot_ctrl_t              slot_ctrl;
    logic                    field_neg;
    logic [ENERGY_W-1:0]     energy_sat;
    logic [ENERGY_W-1:0]     energy_field;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_op    = op_t'(s_tuser);
    assign in_row   = s_tdata[ROW_LSB +: ROW_W];
    assign in_col   = s_tdata[COL_LSB +: ROW_W];
    assign in_wval  = s_tdata[WVAL_LSB +: WVAL_W];
    assign in_nin   = s_tdata[NIN_BIT];

    assign row_ok   = CMP_W'(in_row) < CMP_W'(MAX_NEURONS);
    assign col_ok   = CMP_W'(in_col) < CMP_W'(MAX_NEURONS);
    assign pair_bad = !row_ok || !col_ok || (in_row == in_col);

    always_comb begin
        unique case (in_op)
            OP_WR_WEIGHT:               in_bad = pair_bad;
            OP_WR_NEURON, OP_RD_NEURON: in_bad = !row_ok;
            default:                    in_bad = 1'b0;
        endcase
    end

    always_comb begin
        wv_ext = WX_W'(in_wval);
        if (wv_ext > WMAX) begin
            wv_sat = WEIGHT_BITS'(WMAX);
        end else if (wv_ext < WMIN) begin
            wv_sat = WEIGHT_BITS'(WMIN);
        end else begin
            wv_sat = WEIGHT_BITS'(wv_ext);
        end
    end

    always_comb begin
        act_ext = CMP_W'(active_reg);
        if (act_ext < CMP_W'(2)) begin
            act_count = CMP_W'(2);
        end else if (act_ext > CMP_W'(MAX_NEURONS)) begin
            act_count = CMP_W'(MAX_NEURONS);
        end else begin
            act_count = act_ext;
        end
    end

    // APB register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE);
    assign prdata    = (paddr[2] == REG_ACTIVE) ? APB_DW'(active_reg) : '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (in_op)
                        OP_WR_WEIGHT:          state_next = pair_bad ? ST_FIN : ST_WMUL;
                        OP_RD_NEURON:          state_next = row_ok ? ST_RDWAIT : ST_FIN;
                        OP_UPDATE, OP_ENERGY:  state_next = ST_ROW;
                        default:               state_next = ST_FIN;
                    endcase
                end
            end
            ST_WMUL:   state_next = ST_WADDR;
            ST_WADDR:  state_next = ST_FIN;
            ST_RDWAIT: state_next = ST_FIN;
            ST_ROW:    state_next = ST_SCAN;
            ST_SCAN:   state_next = (j_reg == last_reg) ? ST_DRAIN : ST_SCAN;
            ST_DRAIN:  state_next = ST_ROWEND;
            ST_ROWEND: begin
                if (i_reg != last_reg) begin
                    state_next = ST_ROW;
                end else if (op_reg == OP_UPDATE) begin
                    state_next = ST_COPY;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_COPY:   state_next = (j_reg == last_reg) ? ST_CDRAIN : ST_COPY;
            ST_CDRAIN: state_next = ST_FIN;
            ST_FIN:    state_next = out_free ? ST_IDLE : ST_FIN;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        nram_we    = 1'b0;
        nram_waddr = IDX_W'(in_row);
        nram_wdata = in_nin;
        nram_raddr = row_reg;
        xram_we    = 1'b0;
        wram_we    = 1'b0;
        fin_load   = 1'b0;
        slot_ctrl  = '0;
        acc_ctrl   = '0;
        acc_ctrl.field_en = accuse_reg;
        acc_ctrl.s_bit    = nram_rdata;
        acc_ctrl.si_bit   = si_reg;
        if (cpv_reg) begin
            nram_we    = 1'b1;
            nram_waddr = cpidx_reg;
            nram_wdata = xram_rdata;
        end
        unique case (state_reg)
            ST_IDLE: begin
                nram_raddr           = IDX_W'(in_row);
                nram_we              = s_accept && (in_op == OP_WR_NEURON) && row_ok;
                slot_ctrl.sweep_init = 1'b1;
                acc_ctrl.energy_clr  = 1'b1;
            end
            ST_WMUL:   slot_ctrl.mul_load = 1'b1;
            ST_WADDR: begin
                slot_ctrl.sel_write = 1'b1;
                wram_we             = 1'b1;
            end
            ST_ROW: begin
                nram_raddr         = i_reg;
                slot_ctrl.row_init = 1'b1;
                acc_ctrl.field_clr = 1'b1;
            end
            ST_SCAN: begin
                nram_raddr        = j_reg;
                slot_ctrl.col_adv = 1'b1;
            end
            ST_ROWEND: begin
                xram_we            = (op_reg == OP_UPDATE);
                acc_ctrl.energy_en = (op_reg == OP_ENERGY);
                slot_ctrl.row_adv  = 1'b1;
            end
            ST_COPY:   nram_raddr = j_reg;
            ST_FIN:    fin_load = out_free;
            default: begin
            end
        endcase
    end

    always_comb begin
        unique case (op_reg)
            OP_UPDATE:    iter_next = (iter_reg != '1) ? iter_reg + ITER_W'(1) : iter_reg;
            OP_CLR_COUNT: iter_next = '0;
            default:      iter_next = iter_reg;
        endcase
    end

    assign energy_field = (op_reg == OP_ENERGY) ? energy_sat : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            iter_reg    <= '0;
            active_reg  <= ACTIVE_RESET;
            accuse_reg  <= 1'b0;
            cpv_reg     <= 1'b0;
            si_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            accuse_reg  <= (state_reg == ST_SCAN) && (j_reg != i_reg);
            cpv_reg     <= (state_reg == ST_COPY);
            si_pend_reg <= (state_reg == ST_ROW);
            if (cfg_write) begin
                active_reg <= pwdata[ACT_W-1:0];
            end
            if (fin_load) begin
                m_valid_reg <= 1'b1;
                iter_reg    <= iter_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg      <= in_op;
            row_reg     <= IDX_W'(in_row);
            col_reg     <= IDX_W'(in_col);
            wval_reg    <= wv_sat;
            bad_reg     <= in_bad;
            nout_reg    <= 1'b0;
            changed_reg <= 1'b0;
            last_reg    <= IDX_W'(act_count - CMP_W'(1));
            i_reg       <= '0;
        end
        if (state_reg == ST_ROWEND) begin
            i_reg <= i_reg + IDX_W'(1);
        end
        if (state_reg == ST_SCAN || state_reg == ST_COPY) begin
            j_reg <= j_reg + IDX_W'(1);
        end else begin
            j_reg <= '0;
        end
        cpidx_reg <= j_reg;
        if (si_pend_reg) begin
            si_reg <= nram_rdata;
        end
        if (state_reg == ST_RDWAIT) begin
            nout_reg <= nram_rdata;
        end
        if (cpv_reg && (xram_rdata != nram_rdata)) begin
            changed_reg <= 1'b1;
        end
        if (fin_load) begin
            m_data_reg <= {bad_reg, energy_field, iter_next, changed_reg, nout_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    hsr_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (PAIR_COUNT)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (wram_we),
        .waddr (slot_addr),
        .wdata (wval_reg),
        .raddr (slot_addr),
        .rdata (wram_rdata)
    );

    hsr_ram #(
        .WIDTH (1),
        .DEPTH (MAX_NEURONS)
    ) u_neuron_ram (
        .aclk  (aclk),
        .we    (nram_we),
        .waddr (nram_waddr),
        .wdata (nram_wdata),
        .raddr (nram_raddr),
        .rdata (nram_rdata)
    );

    hsr_ram #(
        .WIDTH (1),
        .DEPTH (MAX_NEURONS)
    ) u_next_ram (
        .aclk  (aclk),
        .we    (xram_we),
        .waddr (i_reg),
        .wdata (!field_neg),
        .raddr (j_reg),
        .rdata (xram_rdata)
    );

    hsr_slot #(
        .MAX_NEURONS (MAX_NEURONS),
        .IDX_W       (IDX_W),
        .ADDR_W      (ADDR_W)
    ) u_slot (
        .aclk      (aclk),
        .ctrl      (slot_ctrl),
        .sweep_i   (i_reg),
        .sweep_j   (j_reg),
        .pair_a    (row_reg),
        .pair_b    (col_reg),
        .slot_addr (slot_addr)
    );

    hsr_accum #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .FIELD_W     (FIELD_W),
        .EACC_W      (EACC_W)
    ) u_accum (
        .aclk       (aclk),
        .ctrl       (acc_ctrl),
        .weight     (wram_rdata),
        .field_neg  (field_neg),
        .energy_sat (energy_sat)
    );

    a_copy_in_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        cpv_reg |-> (state_reg == ST_COPY || state_reg == ST_CDRAIN))
        else $error("copy write outside copy pass");

    a_acc_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accuse_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("field accumulate outside row scan");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW) |-> (i_reg <= last_reg))
        else $error("row index beyond active count");

    a_iter_only_at_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (iter_reg != $past(iter_reg))) |-> ($past(state_reg) == ST_FIN))
        else $error("iteration count changed outside result load");

endmodule

### tb/sv/recall_checker.sv
module recall_checker import hsr_pkg::*; #(
    parameter int MAX_NEURONS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic                       bad_index;
        logic signed [ENERGY_W-1:0] energy_twice;
        logic [ITER_W-1:0]          iteration;
        logic                       state_changed;
        logic                       neuron_out;
    } recall_result_t;

    localparam logic [APB_AW-1:0] ADDR_ACTIVE = APB_AW'(4 * REG_ACTIVE);
    localparam longint ENERGY_HI = (longint'(1) <<< (ENERGY_W - 1)) - 1;
    localparam longint ENERGY_LO = -(longint'(1) <<< (ENERGY_W - 1));

    logic signed [WVAL_W-1:0] weight_copy [int];
    logic                     neuron_copy [MAX_NEURONS];
    logic                     neuron_next [MAX_NEURONS];
    logic [ITER_W-1:0]        iter_copy;
    logic [ACT_W-1:0]         active_copy;
    recall_result_t           expected_results [$];

    function automatic int pair_key(input int a, input int b);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return lo * (2 * MAX_NEURONS - lo - 1) / 2 + hi - lo - 1;
    endfunction

    function automatic int clamped_active();
        if (active_copy < 2) return 2;
        if (active_copy > MAX_NEURONS) return MAX_NEURONS;
        return int'(active_copy);
    endfunction

    function automatic longint field_at(input int i, input int cnt);
        longint sum;
        longint w;
        int     j;
        sum = 0;
        for (j = 0; j < cnt; j++) begin
            if (j != i) begin
                w = weight_copy.exists(pair_key(i, j)) ? longint'(weight_copy[pair_key(i, j)]) : 0;
                sum += neuron_copy[j] ? w : -w;
            end
        end
        return sum;
    endfunction

    task automatic predict_request(input logic [OP_W-1:0] op, input logic [S_TDATA_W-1:0] data,
                                   output recall_result_t r);
        int     row;
        int     col;
        int     cnt;
        int     i;
        longint sum;
        longint h;
        longint en;
        r   = '0;
        row = int'(data[ROW_LSB +: ROW_W]);
        col = int'(data[COL_LSB +: ROW_W]);
        cnt = clamped_active();
        case (op)
            OP_WR_WEIGHT: begin
                if (row >= MAX_NEURONS || col >= MAX_NEURONS || row == col) begin
                    r.bad_index = 1'b1;
                end else begin
                    weight_copy[pair_key(row, col)] = data[WVAL_LSB +: WVAL_W];
                end
            end
            OP_WR_NEURON: begin
                if (row >= MAX_NEURONS) r.bad_index = 1'b1;
                else neuron_copy[row] = data[NIN_BIT];
            end
            OP_RD_NEURON: begin
                if (row >= MAX_NEURONS) r.bad_index = 1'b1;
                else r.neuron_out = neuron_copy[row];
            end
            OP_UPDATE: begin
                for (i = 0; i < cnt; i++) neuron_next[i] = (field_at(i, cnt) >= 0);
                for (i = 0; i < cnt; i++) begin
                    if (neuron_next[i] != neuron_copy[i]) r.state_changed = 1'b1;
                    neuron_copy[i] = neuron_next[i];
                end
                if (iter_copy != '1) iter_copy++;
            end
            OP_ENERGY: begin
                sum = 0;
                for (i = 0; i < cnt; i++) begin
                    h = field_at(i, cnt);
                    sum += neuron_copy[i] ? h : -h;
                end
                en = -sum;
                if (en > ENERGY_HI) en = ENERGY_HI;
                if (en < ENERGY_LO) en = ENERGY_LO;
                r.energy_twice = en[ENERGY_W-1:0];
            end
            OP_CLR_COUNT: iter_copy = '0;
            default: ;
        endcase
        r.iteration = iter_copy;
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        recall_result_t got;
        recall_result_t want;
        if (!aresetn) begin
            iter_copy   = '0;
            active_copy = ACTIVE_RESET;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_ACTIVE) begin
                active_copy = pwdata[ACT_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                predict_request(s_tuser, s_tdata, want);
                expected_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_results.size() == 0) begin
                    flag_mismatch("result with no request waiting", 0, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.neuron_out !== want.neuron_out)
                        flag_mismatch("neuron_out", got.neuron_out, want.neuron_out);
                    if (got.state_changed !== want.state_changed)
                        flag_mismatch("state_changed", got.state_changed, want.state_changed);
                    if (got.iteration !== want.iteration)
                        flag_mismatch("iteration", got.iteration, want.iteration);
                    if (got.energy_twice !== want.energy_twice)
                        flag_mismatch("energy_twice", got.energy_twice, want.energy_twice);
                    if (got.bad_index !== want.bad_index)
                        flag_mismatch("bad_index", got.bad_index, want.bad_index);
                end
            end
        end
        pending <= expected_results.size();
    end

endmodule

### tb/sv/tb.sv
module tb import hsr_pkg::*;;

    localparam int NEURONS        = 1024;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_COUNT    = 9;
    localparam int PHASE_ITEMS    = 6;

    localparam logic [APB_AW-1:0] ADDR_ACTIVE = APB_AW'(4 * REG_ACTIVE);
    localparam logic [OP_W-1:0]   OP_SPARE_6  = 3'd6;
    localparam logic [OP_W-1:0]   OP_SPARE_7  = 3'd7;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SLOW
    } rx_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int       fail_count;
    int       pending;
    int       quiet_cycles  = 0;
    int       burst_left    = 0;
    int       sent_count    = 0;
    int       update_count  = 0;
    int       energy_count  = 0;
    int       setting_count = 0;
    int       ready_n       = 0;
    int       mode_left     = 0;
    rx_mode_t rx_mode       = RX_FREE;
    bit       row_known [NEURONS];
    int       written_rows [$];

    always #5 aclk = ~aclk;

    hopfield_synchronous_recall #(
        .MAX_NEURONS (NEURONS),
        .WEIGHT_BITS (16)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    recall_checker #(
        .MAX_NEURONS (NEURONS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 2));
            mode_left <= $urandom_range(16, 80);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_FREE: m_tready <= 1'b1;
            RX_COIN: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("hopfield_synchronous_recall test failed");
            $finish;
        end
    end

    function automatic logic [WVAL_W-1:0] pick_weight();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 16'h7FFF;
        if (pick == 1) return 16'h8000;
        return WVAL_W'($urandom);
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input int row, input int col,
                                input logic [WVAL_W-1:0] wval, input logic nin);
        logic [S_TDATA_W-1:0] data;
        data = '0;
        data[ROW_LSB +: ROW_W]   = ROW_W'(row);
        data[COL_LSB +: ROW_W]   = ROW_W'(col);
        data[WVAL_LSB +: WVAL_W] = wval;
        data[NIN_BIT]            = nin;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        sent_count++;
        if (op == OP_UPDATE) update_count++;
        if (op == OP_ENERGY) energy_count++;
        if (op == OP_WR_NEURON && !row_known[row]) begin
            row_known[row] = 1'b1;
            written_rows.push_back(row);
        end
    endtask

    // hold off until every request has its result
    task automatic wait_idle();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_active(input int value);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_ACTIVE;
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        setting_count++;
    endtask

    // fill every weight pair and neuron below cnt so sweeps read only written entries
    task automatic prepare_prefix(input int cnt);
        int n;
        int j;
        for (n = ready_n; n < cnt; n++) begin
            for (j = 0; j < n; j++) begin
                if ($urandom_range(0, 1))
                    send_request(OP_WR_WEIGHT, j, n, pick_weight(), 1'($urandom));
                else
                    send_request(OP_WR_WEIGHT, n, j, pick_weight(), 1'($urandom));
            end
            send_request(OP_WR_NEURON, n, $urandom_range(0, NEURONS - 1), WVAL_W'($urandom),
                         1'($urandom));
        end
        if (cnt > ready_n) ready_n = cnt;
    endtask

    task automatic random_request(input int cnt, input bit sweeps_ok);
        int                pick;
        int                a;
        int                b;
        int                nr;
        int                nc;
        logic [WVAL_W-1:0] nw;
        logic              nb;
        pick = sweeps_ok ? $urandom_range(0, 99) : $urandom_range(40, 99);
        a    = $urandom_range(0, cnt - 1);
        b    = (a + $urandom_range(1, cnt - 1)) % cnt;
        nr   = $urandom_range(0, NEURONS - 1);
        nc   = $urandom_range(0, NEURONS - 1);
        nw   = WVAL_W'($urandom);
        nb   = 1'($urandom);
        if (pick < 30) send_request(OP_UPDATE, nr, nc, nw, nb);
        else if (pick < 40) send_request(OP_ENERGY, nr, nc, nw, nb);
        else if (pick < 55) send_request(OP_WR_WEIGHT, a, b, pick_weight(), nb);
        else if (pick < 65) send_request(OP_WR_NEURON, a, nc, nw, nb);
        else if (pick < 72) send_request(OP_WR_NEURON, nr, nc, nw, nb);
        else if (pick < 82)
            send_request(OP_RD_NEURON, written_rows[$urandom_range(0, written_rows.size() - 1)],
                         nc, nw, nb);
        else if (pick < 88) send_request(OP_WR_WEIGHT, nr, nc, pick_weight(), nb);
        else if (pick < 91) send_request(OP_WR_WEIGHT, nr, nr, nw, nb);
        else if (pick < 96) send_request(OP_CLR_COUNT, nr, nc, nw, nb);
        else send_request($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, nr, nc, nw, nb);
    endtask

    initial begin
        int phase_values [PHASE_COUNT];
        int eff;
        int p;
        int k;
        phase_values = '{0, 2047, 5, 1, 9, 1024, 3, 2, 6};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // table requests at the reset setting
        send_request(OP_WR_WEIGHT, 0, 1023, 16'h7FFF, 1'b1);
        send_request(OP_WR_WEIGHT, 1023, 1022, 16'h8000, 1'b0);
        send_request(OP_WR_WEIGHT, 5, 5, 16'h1234, 1'b1);
        send_request(OP_WR_WEIGHT, 1023, 1023, 16'hFFFF, 1'b0);
        send_request(OP_WR_NEURON, 1023, 1023, 16'hFFFF, 1'b1);
        send_request(OP_WR_NEURON, 0, 0, 16'h0000, 1'b0);
        send_request(OP_RD_NEURON, 1023, 1023, 16'hFFFF, 1'b1);
        send_request(OP_RD_NEURON, 0, 0, 16'h0000, 1'b0);
        send_request(OP_SPARE_6, 1023, 1023, 16'hFFFF, 1'b1);
        send_request(OP_SPARE_7, 0, 0, 16'h0000, 1'b0);
        send_request(OP_CLR_COUNT, 512, 512, 16'h5555, 1'b1);

        // below-range setting acts as two neurons
        write_active(0);
        send_request(OP_WR_WEIGHT, 1, 0, 16'h0000, 1'b0);
        send_request(OP_WR_NEURON, 1, 0, 16'h0000, 1'b0);
        send_request(OP_UPDATE, 0, 0, 16'h0000, 1'b0);
        send_request(OP_UPDATE, 1023, 1023, 16'hFFFF, 1'b1);
        send_request(OP_ENERGY, 0, 0, 16'h0000, 1'b0);
        send_request(OP_WR_WEIGHT, 0, 1, 16'h8000, 1'b1);
        send_request(OP_ENERGY, 1023, 1023, 16'hFFFF, 1'b1);
        send_request(OP_UPDATE, 0, 0, 16'h0000, 1'b0);
        send_request(OP_RD_NEURON, 1, 0, 16'h0000, 1'b0);
        send_request(OP_WR_NEURON, 1023, 0, 16'h0000, 1'b0);
        send_request(OP_CLR_COUNT, 0, 0, 16'h0000, 1'b0);
        send_request(OP_UPDATE, 0, 0, 16'h0000, 1'b0);
        send_request(OP_RD_NEURON, 1023, 0, 16'h0000, 1'b0);
        ready_n = 2;

        for (p = 0; p < PHASE_COUNT; p++) begin
            write_active(phase_values[p]);
            eff = (phase_values[p] < 2) ? 2 :
                  (phase_values[p] > NEURONS) ? NEURONS : phase_values[p];
            if (eff <= 16) prepare_prefix(eff);
            for (k = 0; k < PHASE_ITEMS; k++) random_request(eff, eff <= 16);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests, %0d updates and %0d energy reports", sent_count,
                 update_count, energy_count);
        $display("over %0d active_neurons settings, %0d result mismatches", setting_count,
                 fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("hopfield_synchronous_recall test passed");
        end else begin
            $display("hopfield_synchronous_recall test failed");
        end
        $finish;
    end

endmodule
